>>> design/fcfs_pkg.sv
// Shared types and constants for the FCFS schedule metrics block.
// No dependencies; used by fcfs_ctrl, fcfs_dp and fcfs_schedule_metrics.
package fcfs_pkg;

  localparam int unsigned IdW     = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned TimeW   = 21;
  localparam int unsigned AvgW    = 25;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 160;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_COMMIT,
    ST_DIV,
    ST_AVG,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sched_init;
    logic scan_init;
    logic scan_step;
    logic commit;
    logic div_init;
    logic div_step;
    logic avg_set;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pass_last;
    logic div_done;
    logic out_last;
  } sts_t;

endpackage

>>> design/fcfs_dp.sv
// Datapath: record memory, ordered scan, FCFS timing, averaging divider.
// Depends on fcfs_pkg; driven by fcfs_ctrl commands.
module fcfs_dp #(
  parameter int unsigned MaxProcs = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcfs_pkg::cmd_t                  cmd_i,
  output fcfs_pkg::sts_t                  sts_o,
  input  logic [fcfs_pkg::InDataW-1:0]    in_data_i,
  output logic [fcfs_pkg::OutDataW-1:0]   out_data_o,
  output logic                            dropped_o,
  output logic                            last_o
);

  localparam int unsigned CW  = $clog2(MaxProcs + 1);
  localparam int unsigned AW  = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned FW  = fcfs_pkg::TickW + CW;
  localparam int unsigned SW  = FW + CW;
  localparam int unsigned DW  = SW + 4;
  localparam int unsigned NW  = $clog2(DW + 1);
  localparam int unsigned XW  = (FW > fcfs_pkg::TimeW) ? FW : fcfs_pkg::TimeW;
  localparam int unsigned QW  = (DW > fcfs_pkg::AvgW) ? DW : fcfs_pkg::AvgW;
  localparam int unsigned RecW = fcfs_pkg::IdW + 2 * fcfs_pkg::TickW;
  localparam logic [XW-1:0] TimeMax = XW'((1 << fcfs_pkg::TimeW) - 1);
  localparam logic [QW-1:0] AvgMax  = QW'((1 << fcfs_pkg::AvgW) - 1);

  logic [RecW-1:0] mem [MaxProcs];
  logic [RecW-1:0] rdata_q;
  logic [CW-1:0]   cnt_q, scan_q, ridx_q, pass_q, best_idx_q, prev_idx_q;
  logic            ovf_q, rvld_q, best_vld_q, prev_vld_q;
  logic [fcfs_pkg::TickW-1:0] best_arr_q, best_bur_q, prev_arr_q;
  logic [fcfs_pkg::IdW-1:0]   best_id_q;
  logic [FW-1:0]   finish_q;
  logic [SW-1:0]   sumw_q, sumt_q;
  logic [DW-1:0]   qw_q, qt_q;
  logic [CW:0]     rw_q, rt_q;
  logic [NW-1:0]   dcnt_q;
  logic [fcfs_pkg::OutDataW-1:0] out_q;
  logic            last_q;

  logic [fcfs_pkg::TickW-1:0] r_arr;
  logic [fcfs_pkg::IdW-1:0]   r_id;
  logic [fcfs_pkg::TickW-1:0] r_bur;
  logic            cand_ok, better;
  logic [FW-1:0]   arr_x, start_v, wait_v, turn_v;
  logic [SW-1:0]   sumw_nx, sumt_nx;
  logic [CW:0]     rw_sh, rt_sh, n_x;
  logic [XW-1:0]   start_x, wait_x, turn_x;
  logic [QW-1:0]   qw_x, qt_x;

  assign r_id  = rdata_q[fcfs_pkg::IdW-1:0];
  assign r_arr = rdata_q[fcfs_pkg::IdW +: fcfs_pkg::TickW];
  assign r_bur = rdata_q[fcfs_pkg::IdW + fcfs_pkg::TickW +: fcfs_pkg::TickW];

  assign cand_ok = !prev_vld_q || (r_arr > prev_arr_q) ||
                   ((r_arr == prev_arr_q) && (ridx_q > prev_idx_q));
  assign better  = !best_vld_q || (r_arr < best_arr_q);

  assign arr_x   = FW'(best_arr_q);
  assign start_v = (finish_q > arr_x) ? finish_q : arr_x;
  assign wait_v  = start_v - arr_x;
  assign turn_v  = wait_v + FW'(best_bur_q);
  assign start_x = XW'(start_v);
  assign wait_x  = XW'(wait_v);
  assign turn_x  = XW'(turn_v);
  assign sumw_nx = sumw_q + SW'(wait_v);
  assign sumt_nx = sumt_q + SW'(turn_v);

  assign n_x   = {1'b0, cnt_q};
  assign rw_sh = {rw_q[CW-1:0], qw_q[DW-1]};
  assign rt_sh = {rt_q[CW-1:0], qt_q[DW-1]};
  assign qw_x  = QW'(qw_q);
  assign qt_x  = QW'(qt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CW'(MaxProcs))) begin
      mem[cnt_q[AW-1:0]] <= in_data_i[RecW-1:0];
    end
    if (cmd_i.scan_step && (scan_q < cnt_q)) begin
      rdata_q <= mem[scan_q[AW-1:0]];
      ridx_q  <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      scan_q     <= '0;
      rvld_q     <= 1'b0;
      best_vld_q <= 1'b0;
      prev_vld_q <= 1'b0;
      pass_q     <= '0;
      dcnt_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (cnt_q < CW'(MaxProcs)) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.sched_init) begin
        pass_q     <= '0;
        prev_vld_q <= 1'b0;
      end
      if (cmd_i.scan_init) begin
        scan_q     <= '0;
        rvld_q     <= 1'b0;
        best_vld_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (scan_q < cnt_q) begin
          scan_q <= scan_q + 1'b1;
          rvld_q <= 1'b1;
        end else begin
          rvld_q <= 1'b0;
        end
        if (rvld_q && cand_ok && better) begin
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        pass_q     <= pass_q + 1'b1;
        prev_vld_q <= 1'b1;
        last_q     <= (pass_q + 1'b1 == cnt_q);
      end
      if (cmd_i.div_init) begin
        dcnt_q <= NW'(DW);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.out_done && last_q) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_init) begin
      finish_q <= '0;
      sumw_q   <= '0;
      sumt_q   <= '0;
    end
    if (cmd_i.scan_step && rvld_q && cand_ok && better) begin
      best_arr_q <= r_arr;
      best_bur_q <= r_bur;
      best_id_q  <= r_id;
      best_idx_q <= ridx_q;
    end
    if (cmd_i.commit) begin
      prev_arr_q <= best_arr_q;
      prev_idx_q <= best_idx_q;
      finish_q   <= start_v + FW'(best_bur_q);
      sumw_q     <= sumw_nx;
      sumt_q     <= sumt_nx;
      out_q      <= {7'b0000000, {(2 * fcfs_pkg::AvgW){1'b0}},
                     fcfs_pkg::TimeW'((turn_x > TimeMax) ? TimeMax : turn_x),
                     fcfs_pkg::TimeW'((wait_x > TimeMax) ? TimeMax : wait_x),
                     fcfs_pkg::TimeW'((start_x > TimeMax) ? TimeMax : start_x),
                     best_bur_q, best_arr_q, best_id_q};
    end
    // div_init only comes with the final commit: include that record's times
    if (cmd_i.div_init) begin
      qw_q <= {sumw_nx, 4'b0000};
      qt_q <= {sumt_nx, 4'b0000};
      rw_q <= '0;
      rt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rw_sh >= n_x) begin
        rw_q <= rw_sh - n_x;
        qw_q <= {qw_q[DW-2:0], 1'b1};
      end else begin
        rw_q <= rw_sh;
        qw_q <= {qw_q[DW-2:0], 1'b0};
      end
      if (rt_sh >= n_x) begin
        rt_q <= rt_sh - n_x;
        qt_q <= {qt_q[DW-2:0], 1'b1};
      end else begin
        rt_q <= rt_sh;
        qt_q <= {qt_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.avg_set) begin
      out_q[152:103] <= {fcfs_pkg::AvgW'((qt_x > AvgMax) ? AvgMax : qt_x),
                         fcfs_pkg::AvgW'((qw_x > AvgMax) ? AvgMax : qw_x)};
    end
  end

  assign sts_o.scan_done = (scan_q >= cnt_q) && !rvld_q;
  assign sts_o.pass_last = (pass_q + 1'b1 == cnt_q);
  assign sts_o.div_done  = (dcnt_q == '0);
  assign sts_o.out_last  = last_q;
  assign out_data_o      = out_q;
  assign dropped_o       = ovf_q;
  assign last_o          = last_q;

endmodule

>>> design/fcfs_ctrl.sv
// Controller state machine: load, scan, commit, divide, output handshake.
// Depends on fcfs_pkg; commands fcfs_dp.
module fcfs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fcfs_pkg::sts_t sts_i,
  output fcfs_pkg::cmd_t cmd_o
);

  fcfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcfs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      fcfs_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.sched_init = 1'b1;
            cmd_o.scan_init  = 1'b1;
            state_d          = fcfs_pkg::ST_SCAN;
          end
        end
      end
      fcfs_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = fcfs_pkg::ST_COMMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      fcfs_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.pass_last) begin
          cmd_o.div_init = 1'b1;
          state_d        = fcfs_pkg::ST_DIV;
        end else begin
          state_d = fcfs_pkg::ST_OUT;
        end
      end
      fcfs_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = fcfs_pkg::ST_AVG;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      fcfs_pkg::ST_AVG: begin
        cmd_o.avg_set = 1'b1;
        state_d       = fcfs_pkg::ST_OUT;
      end
      fcfs_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_done = 1'b1;
          if (sts_i.out_last) begin
            state_d = fcfs_pkg::ST_LOAD;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = fcfs_pkg::ST_SCAN;
          end
        end
      end
      default: state_d = fcfs_pkg::ST_LOAD;
    endcase
  end

endmodule

>>> design/fcfs_schedule_metrics.sv
// Channel  Dir  Signals                       Content
// s_axis   in   tdata[39:0], tlast            proc_id, arrival, burst; tlast = last_in
// m_axis   out  tdata[159:0], tuser, tlast    result fields; tuser = dropped; tlast = last_out
// Records load one per cycle. After the record with tlast, each result takes
// one pass over the N held records through the memory read port, then commit
// and output; the last result also runs the serial divider and the average update.
// Reset empties the record count; the memory itself is not cleared.
// A stalled result holds the block until taken; no input is taken until done.
// Top level; depends on fcfs_pkg, fcfs_ctrl, fcfs_dp.
module fcfs_schedule_metrics #(
  parameter int unsigned MaxProcs = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] proc_id, [23:8] arrival, [39:24] burst
  input  logic [fcfs_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_id, [23:8] out_arrival, [39:24] out_burst, [60:40] start_time,
  // [81:61] wait_time, [102:82] turnaround, [127:103] avg_wait_x16,
  // [152:128] avg_turn_x16, [159:153] zero
  output logic [fcfs_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] dropped
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  fcfs_pkg::cmd_t cmd;
  fcfs_pkg::sts_t sts;

  fcfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fcfs_dp #(
    .MaxProcs (MaxProcs)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .dropped_o  (m_axis_tuser),
    .last_o     (m_axis_tlast)
  );

endmodule

>>> verif/fcfs_schedule_metrics_tb.sv
// Testbench for fcfs_schedule_metrics: loads process record sets, predicts the
// first-come-first-served schedule and averages, checks every result transaction.
// Depends on fcfs_pkg and the fcfs_schedule_metrics RTL.
module fcfs_schedule_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Procs = 16;
  localparam longint unsigned TimeMax = 2097151;
  localparam longint unsigned AvgMax = 33554431;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [20:0] start;
    logic [20:0] wait_t;
    logic [20:0] turn;
    logic [24:0] avg_wait;
    logic [24:0] avg_turn;
    logic        dropped;
    logic        last;
  } sched_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [fcfs_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [fcfs_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  fcfs_schedule_metrics #(.MaxProcs(Procs)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  rec_t   held_q[$];
  logic   held_overflow = 1'b0;
  sched_t expected_q[$];
  int     errors = 0;
  int     results_seen = 0;
  int     sets_done = 0;

  function automatic longint unsigned sat(longint unsigned v, longint unsigned lim);
    return v > lim ? lim : v;
  endfunction

  // Stores one record; on the last record of a set pushes the expected schedule.
  task automatic predict_schedule(rec_t r);
    rec_t order[$];
    longint unsigned fin, arr, bur, st, wt, tn, sum_w, sum_t;
    int n, j;
    sched_t e;
    fin = 0; sum_w = 0; sum_t = 0;
    if (held_q.size() < Procs) held_q.push_back(r);
    else held_overflow = 1'b1;
    if (!r.last) return;
    n = held_q.size();
    foreach (held_q[i]) begin
      j = order.size();
      while (j > 0 && order[j-1].arrival > held_q[i].arrival) j--;
      order.insert(j, held_q[i]);
    end
    foreach (order[i]) begin
      arr = 64'(order[i].arrival);
      bur = 64'(order[i].burst);
      st = fin > arr ? fin : arr;
      wt = st - arr;
      tn = wt + bur;
      fin = st + bur;
      sum_w += wt;
      sum_t += tn;
      e = '0;
      e.id = order[i].id;
      e.arrival = order[i].arrival;
      e.burst = order[i].burst;
      e.start = 21'(sat(st, TimeMax));
      e.wait_t = 21'(sat(wt, TimeMax));
      e.turn = 21'(sat(tn, TimeMax));
      e.dropped = held_overflow;
      if (i == n - 1) begin
        e.avg_wait = 25'(sat((sum_w * 16) / n, AvgMax));
        e.avg_turn = 25'(sat((sum_t * 16) / n, AvgMax));
        e.last = 1'b1;
      end
      expected_q.push_back(e);
    end
    held_q.delete();
    held_overflow = 1'b0;
  endtask

  // Receiver: stalls on its own pattern, checks each result transaction.
  int stall_mode = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    sched_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.id = m_axis_tdata[7:0];
      got.arrival = m_axis_tdata[23:8];
      got.burst = m_axis_tdata[39:24];
      got.start = m_axis_tdata[60:40];
      got.wait_t = m_axis_tdata[81:61];
      got.turn = m_axis_tdata[102:82];
      got.avg_wait = m_axis_tdata[127:103];
      got.avg_turn = m_axis_tdata[152:128];
      got.dropped = m_axis_tuser;
      got.last = m_axis_tlast;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r || m_axis_tdata[159:153] !== '0) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  task automatic send_record(rec_t r);
    s_axis_tdata <= {r.burst, r.arrival, r.id};
    s_axis_tlast <= r.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_schedule(r);
    if (r.last) sets_done++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Directed table: extremes, single record, ties, two maximal bursts at arrival zero.
  rec_t directed[] = '{
    '{8'h00, 16'h0000, 16'h0000, 1'b1},
    '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b1},
    '{8'h01, 16'd10, 16'd5, 1'b0},
    '{8'h02, 16'd0, 16'd3, 1'b0},
    '{8'h03, 16'd10, 16'd1, 1'b0},
    '{8'h04, 16'd0, 16'd7, 1'b1},
    '{8'hAA, 16'd0, 16'hFFFF, 1'b0},
    '{8'h55, 16'd0, 16'hFFFF, 1'b1}
  };

  initial begin
    rec_t r;
    int burst_len, set_len, kind;
    sched_t exp0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // a lone zero record: everything in the result reads zero except last
    exp0 = '0;
    exp0.last = 1'b1;
    foreach (directed[i]) begin
      send_record(directed[i]);
      if (i == 0 && expected_q[$] !== exp0) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp0, expected_q[$]);
        errors++;
      end
    end
    idle_gap(1);
    // 20 long records: full store, then dropped records and a dropped last
    for (int i = 0; i < 20; i++) begin
      r.id = 8'(i); r.arrival = 16'd0; r.burst = 16'hFFFF; r.last = (i == 19);
      send_record(r);
    end
    idle_gap(3);
    // random sets: mostly small, a few full or overflowing
    burst_len = 0;
    for (int n = 0; n < 350; ) begin
      kind = $urandom_range(0, 9);
      set_len = kind < 7 ? $urandom_range(1, 5) :
                kind < 9 ? $urandom_range(6, 16) : $urandom_range(17, 20);
      for (int i = 0; i < set_len; i++) begin
        r.id = 8'($urandom);
        r.arrival = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        r.burst = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        r.last = (i == set_len - 1);
        send_record(r);
        n++;
        if (burst_len == 0) begin
          burst_len = $urandom_range(1, 12);
          idle_gap($urandom_range(0, 4));
        end else burst_len--;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d record sets and %0d result transactions, incl. dropped records.",
             sets_done, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
